FILE: src/matrix_inverse_3x3_unit_defines.svh
// assertion helpers for the matrix inverse unit
`ifndef MATRIX_INVERSE_3X3_UNIT_DEFINES_SVH
`define MATRIX_INVERSE_3X3_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define MI3_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define MI3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/mi3_pkg.sv
`timescale 1ns / 1ps

package mi3_pkg;

    localparam int NUM_EL    = 9;
    localparam int W_IN      = 16;
    localparam int W_PROD    = 32;
    localparam int W_COF     = 33;
    localparam int W_DP      = 49;
    localparam int W_DET     = 51;
    localparam int W_MAG     = 49;
    localparam int W_Q       = 32;
    localparam int W_EPS     = 47;
    localparam int FRAC      = 28;
    localparam int DIV_STEPS = 32;
    localparam int FRONT_LAT = 6;
    localparam int LANE_LAT  = DIV_STEPS + 1;

    typedef logic [3:0] idx_t;

    // cofactor k = a[PLUS_A]*a[PLUS_B] - a[MINUS_A]*a[MINUS_B]
    localparam idx_t PLUS_A  [NUM_EL] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
    localparam idx_t PLUS_B  [NUM_EL] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
    localparam idx_t MINUS_A [NUM_EL] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
    localparam idx_t MINUS_B [NUM_EL] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

    // adjugate element k takes cofactor TRANS[k]
    localparam idx_t TRANS   [NUM_EL] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

    typedef struct packed {
        logic signed [W_IN-1:0] in_r0c0;
        logic signed [W_IN-1:0] in_r0c1;
        logic signed [W_IN-1:0] in_r0c2;
        logic signed [W_IN-1:0] in_r1c0;
        logic signed [W_IN-1:0] in_r1c1;
        logic signed [W_IN-1:0] in_r1c2;
        logic signed [W_IN-1:0] in_r2c0;
        logic signed [W_IN-1:0] in_r2c1;
        logic signed [W_IN-1:0] in_r2c2;
    } mi3_in_t;

    typedef struct packed {
        logic signed [W_Q-1:0] inv_r0c0;
        logic signed [W_Q-1:0] inv_r0c1;
        logic signed [W_Q-1:0] inv_r0c2;
        logic signed [W_Q-1:0] inv_r1c0;
        logic signed [W_Q-1:0] inv_r1c1;
        logic signed [W_Q-1:0] inv_r1c2;
        logic signed [W_Q-1:0] inv_r2c0;
        logic signed [W_Q-1:0] inv_r2c1;
        logic signed [W_Q-1:0] inv_r2c2;
        logic                  invertible;
    } mi3_out_t;

    typedef struct packed {
        logic              singular;
        logic              dsgn;
        logic [NUM_EL-1:0] csgn;
    } mi3_side_t;

endpackage

FILE: src/mi3_front.sv
`timescale 1ns / 1ps

module mi3_front
    import mi3_pkg::*;
(
    input  logic              clk,
    input  mi3_in_t           matrix,
    input  logic [W_EPS-1:0]  eps,
    output logic [W_Q-1:0]    cmag [NUM_EL],
    output logic [W_MAG-1:0]  dmag,
    output mi3_side_t         side
);

    logic signed [W_IN-1:0]  a_s1_reg   [NUM_EL];
    logic signed [W_PROD-1:0] pp_s2_reg [NUM_EL];
    logic signed [W_PROD-1:0] pm_s2_reg [NUM_EL];
    logic signed [W_IN-1:0]  r0_s2_reg  [3];
    logic signed [W_COF-1:0] cof_s3_reg [NUM_EL];
    logic signed [W_IN-1:0]  r0_s3_reg  [3];
    logic signed [W_DP-1:0]  dp_s4_reg  [3];
    logic signed [W_COF-1:0] cof_s4_reg [NUM_EL];
    logic signed [W_DET-1:0] det_s5_reg;
    logic signed [W_COF-1:0] cof_s5_reg [NUM_EL];
    logic [W_DET-1:0]        det_abs;
    logic [W_COF-1:0]        cof_abs    [NUM_EL];
    logic [W_Q-1:0]          cmag_reg   [NUM_EL];
    logic [W_MAG-1:0]        dmag_reg;
    mi3_side_t               side_reg;

    always_ff @(posedge clk)
    begin
        a_s1_reg[0] <= matrix.in_r0c0;
        a_s1_reg[1] <= matrix.in_r0c1;
        a_s1_reg[2] <= matrix.in_r0c2;
        a_s1_reg[3] <= matrix.in_r1c0;
        a_s1_reg[4] <= matrix.in_r1c1;
        a_s1_reg[5] <= matrix.in_r1c2;
        a_s1_reg[6] <= matrix.in_r2c0;
        a_s1_reg[7] <= matrix.in_r2c1;
        a_s1_reg[8] <= matrix.in_r2c2;
    end

    // 2x2 products, cofactors, row 0 expansion
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_EL; k++)
        begin
            pp_s2_reg[k]  <= a_s1_reg[PLUS_A[k]] * a_s1_reg[PLUS_B[k]];
            pm_s2_reg[k]  <= a_s1_reg[MINUS_A[k]] * a_s1_reg[MINUS_B[k]];
            cof_s3_reg[k] <= W_COF'(pp_s2_reg[k]) - W_COF'(pm_s2_reg[k]);
            cof_s4_reg[k] <= cof_s3_reg[k];
            cof_s5_reg[k] <= cof_s4_reg[k];
        end
        for (int j = 0; j < 3; j++)
        begin
            r0_s2_reg[j] <= a_s1_reg[j];
            r0_s3_reg[j] <= r0_s2_reg[j];
            dp_s4_reg[j] <= r0_s3_reg[j] * cof_s3_reg[j];
        end
        det_s5_reg <= W_DET'(dp_s4_reg[0]) + W_DET'(dp_s4_reg[1]) + W_DET'(dp_s4_reg[2]);
    end

    always_comb
    begin
        det_abs = det_s5_reg[W_DET-1] ? W_DET'(-det_s5_reg) : W_DET'(det_s5_reg);
        for (int k = 0; k < NUM_EL; k++)
        begin
            cof_abs[k] = cof_s5_reg[k][W_COF-1] ? W_COF'(-cof_s5_reg[k])
                                                : W_COF'(cof_s5_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        dmag_reg          <= det_abs[W_MAG-1:0];
        side_reg.singular <= (det_abs <= W_DET'(eps));
        side_reg.dsgn     <= det_s5_reg[W_DET-1];
        for (int k = 0; k < NUM_EL; k++)
        begin
            cmag_reg[k]      <= cof_abs[TRANS[k]][W_Q-1:0];
            side_reg.csgn[k] <= cof_s5_reg[TRANS[k]][W_COF-1];
        end
    end

    assign cmag = cmag_reg;
    assign dmag = dmag_reg;
    assign side = side_reg;

endmodule

FILE: src/mi3_div_lane.sv
`timescale 1ns / 1ps

module mi3_div_lane
    import mi3_pkg::*;
(
    input  logic             clk,
    input  logic [W_Q-1:0]   num,
    input  logic [W_MAG-1:0] den,
    output logic [W_Q-1:0]   quo,
    output logic             ovf
);

    localparam int HI_SH = W_Q - FRAC;

    logic [W_MAG-1:0] rem_reg [DIV_STEPS+1];
    logic [W_MAG-1:0] den_reg [DIV_STEPS+1];
    logic [W_Q-1:0]   low_reg [DIV_STEPS+1];
    logic [W_Q-1:0]   q_reg   [DIV_STEPS+1];
    logic             ovf_reg [DIV_STEPS+1];
    logic [W_MAG-1:0] hi;

    // upper part of the shifted numerator; quotient fits 32 bits only if below den
    assign hi = W_MAG'(num >> HI_SH);

    always_ff @(posedge clk)
    begin
        ovf_reg[0] <= (hi >= den);
        rem_reg[0] <= (hi >= den) ? '0 : hi;
        den_reg[0] <= den;
        low_reg[0] <= {num[HI_SH-1:0], {FRAC{1'b0}}};
        q_reg[0]   <= '0;
    end

    for (genvar i = 1; i <= DIV_STEPS; i++)
    begin : g_step
        logic [W_MAG:0] trial;
        logic [W_MAG:0] diff;
        logic           ge;

        assign trial = {rem_reg[i-1], low_reg[i-1][W_Q-1]};
        assign diff  = trial - {1'b0, den_reg[i-1]};
        assign ge    = (trial >= {1'b0, den_reg[i-1]});

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= ge ? diff[W_MAG-1:0] : trial[W_MAG-1:0];
            q_reg[i]   <= {q_reg[i-1][W_Q-2:0], ge};
            low_reg[i] <= {low_reg[i-1][W_Q-2:0], 1'b0};
            den_reg[i] <= den_reg[i-1];
            ovf_reg[i] <= ovf_reg[i-1];
        end
    end

    assign quo = q_reg[DIV_STEPS];
    assign ovf = ovf_reg[DIV_STEPS];

endmodule

FILE: src/matrix_inverse_3x3_unit.sv
`timescale 1ns / 1ps
// channel   | signals                         | request taken when
// ----------+---------------------------------+--------------------------
// matrix in | start, busy, matrix             | start high, busy low
// result    | done, result                    | the cycle done is high
// config    | cfg_valid, cfg_ready, cfg_data  | cfg_valid and cfg_ready high
//
// one matrix per cycle; each result passes the front end, the divider lanes and the output register
// most of the latency lies in the 32-stage restoring divider in each of the nine lanes
// busy stays low and cfg_ready stays high: the pipeline never stalls
// reset clears the valid pipeline, the strobe and det_epsilon
// the receiver cannot stall; results are dropped onto the ports as they finish
`include "matrix_inverse_3x3_unit_defines.svh"

module matrix_inverse_3x3_unit
    import mi3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  mi3_in_t          matrix,
    output logic             done,
    output mi3_out_t         result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [W_EPS-1:0] cfg_data
);

    localparam int PIPE_LAT = FRONT_LAT + LANE_LAT;
    localparam int TOT_LAT  = PIPE_LAT + 1;

    logic [W_EPS-1:0]    eps_reg;
    logic [PIPE_LAT-1:0] vld_reg;
    logic                done_reg;
    mi3_out_t            result_reg;
    mi3_out_t            result_next;
    logic [W_Q-1:0]      cmag [NUM_EL];
    logic [W_MAG-1:0]    dmag;
    mi3_side_t           side_front;
    mi3_side_t           side_reg [LANE_LAT];
    mi3_side_t           side_end;
    logic [W_Q-1:0]      quo  [NUM_EL];
    logic                ovf  [NUM_EL];
    logic [W_Q-1:0]      val  [NUM_EL];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg  <= '0;
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                eps_reg <= cfg_data;
            end
            vld_reg  <= {vld_reg[PIPE_LAT-2:0], start && !busy};
            done_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    mi3_front u_front (
        .clk    (clk),
        .matrix (matrix),
        .eps    (eps_reg),
        .cmag   (cmag),
        .dmag   (dmag),
        .side   (side_front)
    );

    for (genvar k = 0; k < NUM_EL; k++)
    begin : g_lane
        mi3_div_lane u_lane (
            .clk (clk),
            .num (cmag[k]),
            .den (dmag),
            .quo (quo[k]),
            .ovf (ovf[k])
        );
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_front;
        for (int i = 1; i < LANE_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    assign side_end = side_reg[LANE_LAT-1];

    // sign, saturation and singular zeroing
    always_comb
    begin
        for (int k = 0; k < NUM_EL; k++)
        begin
            if (side_end.singular)
            begin
                val[k] = '0;
            end
            else if (side_end.csgn[k] ^ side_end.dsgn)
            begin
                if (ovf[k] || (quo[k] > {1'b1, {(W_Q-1){1'b0}}}))
                begin
                    val[k] = {1'b1, {(W_Q-1){1'b0}}};
                end
                else
                begin
                    val[k] = W_Q'(-quo[k]);
                end
            end
            else
            begin
                if (ovf[k] || quo[k][W_Q-1])
                begin
                    val[k] = {1'b0, {(W_Q-1){1'b1}}};
                end
                else
                begin
                    val[k] = quo[k];
                end
            end
        end
        result_next.inv_r0c0   = val[0];
        result_next.inv_r0c1   = val[1];
        result_next.inv_r0c2   = val[2];
        result_next.inv_r1c0   = val[3];
        result_next.inv_r1c1   = val[4];
        result_next.inv_r1c2   = val[5];
        result_next.inv_r2c0   = val[6];
        result_next.inv_r2c1   = val[7];
        result_next.inv_r2c2   = val[8];
        result_next.invertible = !side_end.singular;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `MI3_ASSERT_IMPL(a_singular_zero, done && !result.invertible, result == '0, "singular result not cleared")
    `MI3_ASSERT_IMPL(a_done_latency, done, $past(start && !busy, TOT_LAT), "result without request")
    `MI3_ASSERT_NEXT(a_strobe_follows, vld_reg[PIPE_LAT-1], done, "finished request not strobed")

endmodule
